// File: hdl/adcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC frame deframer package
// Shared types and constants for the multichannel ADC frame deframer.
// ----------------------------------------------------------------------------
package adcd_pkg;

   // Channel words per frame, after the status word
   localparam int CHANNEL_COUNT = 8;

   // Field widths
   localparam int BYTE_W   = 8;
   localparam int CHAN_W   = 3;
   localparam int CODE_W   = 24;
   localparam int STATUS_W = 16;
   localparam int POS_W    = 6;
   localparam int WORD_W   = 5;
   localparam int SUB_W    = 2;
   localparam int MODE_W   = 2;

   // Word mode codes
   localparam logic [MODE_W-1:0] MODE_16 = 2'd0;
   localparam logic [MODE_W-1:0] MODE_24 = 2'd1;
   localparam logic [MODE_W-1:0] MODE_32 = 2'd2;

   // Saturation point of the byte position
   localparam logic [POS_W-1:0] POS_MAX = 6'd63;

   // Reciprocal of 3 scaled by 2^7, exact for positions up to 63
   localparam int RECIP3       = 43;
   localparam int RECIP3_SHIFT = 7;

   typedef struct packed {
      logic              device;
      logic              frame_start;
      logic [BYTE_W-1:0] byte_value;
   } req_item_type;

   typedef struct packed {
      logic                     source_device;
      logic [CHAN_W-1:0]        channel;
      logic signed [CODE_W-1:0] sample_code;
      logic [STATUS_W-1:0]      frame_status;
      logic                     last_channel;
   } rsp_item_type;

endpackage
`default_nettype wire

// File: hdl/adcd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC frame deframer channel interfaces
// Valid/ready channels for incoming bytes and outgoing channel samples.
// ----------------------------------------------------------------------------
interface adcd_req_if;
   logic       valid;
   logic       ready;
   logic       device;
   logic       frame_start;
   logic [7:0] byte_value;

   modport source (output valid, device, frame_start, byte_value, input ready);
   modport sink   (input valid, device, frame_start, byte_value, output ready);
endinterface

interface adcd_rsp_if;
   logic               valid;
   logic               ready;
   logic               source_device;
   logic [2:0]         channel;
   logic signed [23:0] sample_code;
   logic [15:0]        frame_status;
   logic               last_channel;

   modport source (output valid, source_device, channel, sample_code, frame_status,
                   last_channel, input ready);
   modport sink   (input valid, source_device, channel, sample_code, frame_status,
                   last_channel, output ready);
endinterface
`default_nettype wire

// File: hdl/adcd_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC deframer input stage
// Registers each incoming byte transaction ahead of the frame parser.
// ----------------------------------------------------------------------------
module adcd_in_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   adcd_req_if.sink                   req,
   input  wire logic                  item_advance,
   output      logic                  item_valid,
   output      adcd_pkg::req_item_type item
);
   import adcd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         accept;

   // Take a new byte when empty or when the held one moves on
   assign req.ready = !valid_ff || item_advance;
   assign accept    = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (item_advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload until the next transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= '{device: req.device, frame_start: req.frame_start,
                      byte_value: req.byte_value};
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

// File: hdl/adcd_parse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC deframer frame parser
// Tracks the byte position in the frame, assembles words, latches status and
// builds one channel sample at the last byte of each channel word.
// ----------------------------------------------------------------------------
module adcd_parse (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [1:0]             csr_write_data,
   input  wire logic                   item_valid,
   input  wire adcd_pkg::req_item_type item,
   input  wire logic                   out_room,
   output      logic                   item_advance,
   output      logic                   result_load,
   output      adcd_pkg::rsp_item_type result
);
   import adcd_pkg::*;

   logic [MODE_W-1:0]   word_mode_ff;
   logic [POS_W-1:0]    byte_position_ff;
   logic [POS_W-1:0]    byte_position_in;
   logic [CODE_W-1:0]   word_shift_ff;
   logic [CODE_W-1:0]   word_shift_in;
   logic [STATUS_W-1:0] status_hold_ff;
   logic [STATUS_W-1:0] status_hold_in;

   logic [POS_W-1:0]    pos;
   logic [2*POS_W-1:0]  prod3;
   logic [WORD_W-1:0]   word3;
   logic [POS_W-1:0]    word3x3;
   logic [WORD_W-1:0]   word;
   logic [SUB_W-1:0]    sub;
   logic [SUB_W-1:0]    sub_last;
   logic                emit;
   logic [WORD_W-1:0]   word_less1;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         word_mode_ff <= MODE_24;
      end else if (csr_write_enable) begin
         word_mode_ff <= csr_write_data;
      end
   end

   // Restart the position on a frame start
   assign pos = item.frame_start ? '0 : byte_position_ff;

   // Split the position into word number and byte within the word
   assign prod3   = {{POS_W{1'b0}}, pos} * (2*POS_W)'(RECIP3);
   assign word3   = prod3[RECIP3_SHIFT +: WORD_W];
   assign word3x3 = {1'b0, word3} + {word3, 1'b0};

   always_comb begin
      case (word_mode_ff)
         MODE_16: begin
            word     = pos[POS_W-1:1];
            sub      = {1'b0, pos[0]};
            sub_last = 2'd1;
         end
         MODE_32: begin
            word     = {1'b0, pos[POS_W-1:2]};
            sub      = pos[1:0];
            sub_last = 2'd3;
         end
         default: begin
            word     = word3;
            sub      = SUB_W'(pos - word3x3);
            sub_last = 2'd2;
         end
      endcase
   end

   // Shift in the byte; the fourth byte of a 32-bit word is dropped
   always_comb begin
      word_shift_in = word_shift_ff;
      if (sub != 2'd3) begin
         if (sub == 2'd0) begin
            word_shift_in = {16'h0000, item.byte_value};
         end else begin
            word_shift_in = {word_shift_ff[15:0], item.byte_value};
         end
      end
   end

   // Latch the status after the second frame byte
   assign status_hold_in = (pos == 6'd1) ? word_shift_in[15:0] : status_hold_ff;

   // Advance and saturate the position
   assign byte_position_in = (pos < POS_MAX) ? pos + 6'd1 : POS_MAX;

   // Emit at the last byte of a channel word
   assign emit = (word >= WORD_W'(1)) && (word <= WORD_W'(CHANNEL_COUNT))
                 && (sub == sub_last);

   assign item_advance = item_valid && (!emit || out_room);
   assign result_load  = item_advance && emit;
   assign word_less1   = word - WORD_W'(1);

   always_comb begin
      result.source_device = item.device;
      result.channel       = word_less1[CHAN_W-1:0];
      if (word_mode_ff == MODE_16) begin
         result.sample_code = $signed({word_shift_in[15:0], 8'h00});
      end else begin
         result.sample_code = $signed(word_shift_in);
      end
      result.frame_status  = status_hold_in;
      result.last_channel  = (word == WORD_W'(CHANNEL_COUNT));
   end

   // Frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         word_shift_ff    <= '0;
         status_hold_ff   <= '0;
      end else if (item_advance) begin
         byte_position_ff <= byte_position_in;
         word_shift_ff    <= word_shift_in;
         status_hold_ff   <= status_hold_in;
      end
   end

   // A consumed byte always leaves the position past the frame start
   assert property (@(posedge clock) disable iff (reset)
      item_advance |=> byte_position_ff != '0)
      else $error("byte position did not advance");

   // The first frame byte, part of the status word, never produces a sample
   assert property (@(posedge clock) disable iff (reset)
      (item_advance && (item.frame_start || byte_position_ff == '0)) |-> !result_load)
      else $error("sample emitted on first frame byte");

   // 16-bit codes land at 24-bit weight
   assert property (@(posedge clock) disable iff (reset)
      (result_load && word_mode_ff == MODE_16) |-> result.sample_code[7:0] == 8'h00)
      else $error("16-bit sample not shifted");

endmodule
`default_nettype wire

// File: hdl/adcd_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC deframer output stage
// Result register that holds a sample until the receiver takes it.
// ----------------------------------------------------------------------------
module adcd_out_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   result_load,
   input  wire adcd_pkg::rsp_item_type result,
   output      logic                   out_room,
   adcd_rsp_if.source                  rsp
);
   import adcd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type result_ff;

   // Room when empty or when the held sample leaves this cycle
   assign out_room = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      if (result_load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         result_ff <= result;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.source_device = result_ff.source_device;
   assign rsp.channel       = result_ff.channel;
   assign rsp.sample_code   = result_ff.sample_code;
   assign rsp.frame_status  = result_ff.frame_status;
   assign rsp.last_channel  = result_ff.last_channel;

endmodule
`default_nettype wire

// File: hdl/adc_frame_channel_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC frame channel deframer
// Splits the byte stream of a multichannel ADC frame into channel samples.
//
// req carries one received byte per transaction with its device bit and a
// frame start flag on the first byte of a frame. rsp carries one sample per
// channel word: device, channel, signed 24-bit-weight code, frame status and
// a flag on the last channel. csr_write_enable/csr_write_data set the word
// mode (0: 16-bit, 1: 24-bit, 2: 32-bit); write it only while idle.
// Throughput is one byte per cycle while the result register has room. A byte is
// registered in the input register at acceptance and parsed from there, and its
// sample is loaded into the result register, which drives rsp, once that register
// has room.
// Reset clears both stages and the frame state and selects 24-bit mode; a
// byte arriving after reset without a frame start opens a frame. When the
// receiver stalls, the result register holds its sample and bytes that make
// no sample keep flowing; a byte that completes a word waits in the input
// register, which then deasserts req.ready.
// ----------------------------------------------------------------------------
module adc_frame_channel_deframer (
   input  wire logic       clock,
   input  wire logic       reset,
   adcd_req_if.sink        req,
   adcd_rsp_if.source      rsp,
   input  wire logic       csr_write_enable,
   input  wire logic [1:0] csr_write_data
);
   import adcd_pkg::*;

   logic         item_valid;
   req_item_type item;
   logic         item_advance;
   logic         result_load;
   rsp_item_type result;
   logic         out_room;

   adcd_in_stage u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .item_advance (item_advance),
      .item_valid   (item_valid),
      .item         (item)
   );

   adcd_parse u_parse (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (item_valid),
      .item             (item),
      .out_room         (out_room),
      .item_advance     (item_advance),
      .result_load      (result_load),
      .result           (result)
   );

   adcd_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .result_load (result_load),
      .result      (result),
      .out_room    (out_room),
      .rsp         (rsp)
   );

endmodule
`default_nettype wire

// File: verif/adcd_sample_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC frame deframer sample checker
// Watches the byte and sample channels and the mode register port. It keeps
// its own copy of the frame state, predicts each channel sample, and compares
// every sample that leaves the block with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module adcd_sample_checker (
   input  logic       clock,
   input  logic       reset,
   adcd_req_if        req,
   adcd_rsp_if        rsp,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data,
   output int         pending_samples,
   output int         fail_count
);
   import adcd_pkg::*;

   // Predicted frame state
   logic [MODE_W-1:0]   word_mode_q;
   logic [POS_W-1:0]    frame_pos;
   logic [CODE_W-1:0]   shift_acc;
   logic [STATUS_W-1:0] status_latch;
   rsp_item_type        expected_samples[$];
   int                  mismatches = 0;

   assign fail_count = mismatches;

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string what, input logic [47:0] got,
                                  input logic [47:0] want);
      $display("[%0t] sample check: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   // Advance the frame state by one byte; queue a sample when a channel word ends
   task automatic deframe_byte(input logic dev, input logic fs, input logic [7:0] b);
      int unsigned  pos;
      int unsigned  wbytes;
      int unsigned  word_idx;
      int unsigned  sub;
      rsp_item_type sample;
      pos = fs ? 0 : frame_pos;
      case (word_mode_q)
         MODE_16: wbytes = 2;
         MODE_32: wbytes = 4;
         default: wbytes = 3;
      endcase
      word_idx = pos / wbytes;
      sub      = pos % wbytes;
      // only the first three bytes of a word shift in
      if (sub < 3) begin
         shift_acc = {(sub == 0) ? 16'h0000 : shift_acc[15:0], b};
      end
      if (pos == 1) begin
         status_latch = shift_acc[15:0];
      end
      if (word_idx >= 1 && word_idx <= CHANNEL_COUNT && sub == wbytes - 1) begin
         sample.source_device = dev;
         sample.channel       = CHAN_W'(word_idx - 1);
         sample.sample_code   = (wbytes == 2) ? {shift_acc[15:0], 8'h00} : shift_acc;
         sample.frame_status  = status_latch;
         sample.last_channel  = (word_idx == CHANNEL_COUNT);
         expected_samples.push_back(sample);
      end
      frame_pos = (pos < POS_MAX) ? POS_W'(pos + 1) : POS_MAX;
   endtask

   // Compare delivered samples, then predict from accepted bytes
   always @(posedge clock) begin : monitor
      rsp_item_type seen;
      rsp_item_type want;
      if (reset) begin
         word_mode_q  = MODE_24;
         frame_pos    = '0;
         shift_acc    = '0;
         status_latch = '0;
         expected_samples.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            seen.source_device = rsp.source_device;
            seen.channel       = rsp.channel;
            seen.sample_code   = rsp.sample_code;
            seen.frame_status  = rsp.frame_status;
            seen.last_channel  = rsp.last_channel;
            if (expected_samples.size() == 0) begin
               report_mismatch("sample with none expected:", 48'(seen), 48'h0);
            end else begin
               want = expected_samples.pop_front();
               if (seen.source_device !== want.source_device)
                  report_mismatch("source_device", 48'(seen.source_device),
                                  48'(want.source_device));
               if (seen.channel !== want.channel)
                  report_mismatch("channel", 48'(seen.channel), 48'(want.channel));
               if (seen.sample_code !== want.sample_code)
                  report_mismatch("sample_code", 48'(unsigned'(seen.sample_code)),
                                  48'(unsigned'(want.sample_code)));
               if (seen.frame_status !== want.frame_status)
                  report_mismatch("frame_status", 48'(seen.frame_status),
                                  48'(want.frame_status));
               if (seen.last_channel !== want.last_channel)
                  report_mismatch("last_channel", 48'(seen.last_channel),
                                  48'(want.last_channel));
            end
         end
         if (req.valid && req.ready) begin
            deframe_byte(req.device, req.frame_start, req.byte_value);
         end
         if (csr_write_enable) begin
            word_mode_q = csr_write_data;
         end
      end
      pending_samples <= expected_samples.size();
   end

endmodule

// File: verif/adc_frame_channel_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC frame channel deframer testbench
// Drives byte streams of ADC frames in every word mode, with directed corner
// frames first and then random well-formed, truncated, long and noisy frames.
// Both channels idle at random; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module adc_frame_channel_deframer_tb;
   import adcd_pkg::*;

   // Mode code 3 behaves as 24-bit
   localparam logic [MODE_W-1:0] MODE_ALIAS_24 = 2'd3;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 4;
   localparam int LONG_HOLD     = 300;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable;
   logic [1:0] csr_write_data;
   int         pending_samples;
   int         fail_count;
   int         cycle_count = 0;
   logic [MODE_W-1:0] current_mode = MODE_24;
   bit         quiet_tail = 1'b0;
   bit         sender_steady = 1'b0;
   bit         rsp_hold_request = 1'b0;

   adcd_req_if req_bus ();
   adcd_rsp_if rsp_bus ();

   adc_frame_channel_deframer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   adcd_sample_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .pending_samples  (pending_samples),
      .fail_count       (fail_count)
   );

   always #5 clock = ~clock;

   // Offer one byte and hold it until the transaction completes
   task automatic drive_byte(input logic dev, input logic fs, input logic [7:0] b);
      req_bus.valid       <= 1'b1;
      req_bus.device      <= dev;
      req_bus.frame_start <= fs;
      req_bus.byte_value  <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (!quiet_tail && !sender_steady && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Drain all samples, let the pipeline empty, then set the word mode
   task automatic write_word_mode(input logic [MODE_W-1:0] mode);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_samples != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      current_mode = mode;
   endtask

   // Favor boundary byte values
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         3:       return 8'h7F;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Send random frames until the byte budget is spent
   task automatic run_traffic(input int byte_budget);
      int   sent;
      int   kind;
      int   len;
      int   full_len;
      logic dev;
      logic fs;
      sent = 0;
      while (sent < byte_budget) begin
         full_len = (CHANNEL_COUNT + 2) *
                    ((current_mode == MODE_16) ? 2 : (current_mode == MODE_32) ? 4 : 3);
         kind          = $urandom_range(0, 9);
         dev           = 1'($urandom_range(0, 1));
         sender_steady = ($urandom_range(0, 3) == 0);
         if (kind < 7) len = full_len;
         else if (kind == 7) len = $urandom_range(1, full_len - 1);
         else if (kind == 8) len = $urandom_range(60, 72);
         else len = $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            fs = (kind == 9) ? ($urandom_range(0, 7) == 0) : (i == 0);
            if ($urandom_range(0, 31) == 0) dev = ~dev;
            drive_byte(dev, fs, pick_byte());
            sent++;
         end
      end
   endtask

   // Receiver: random stalls, one long hold-off on request, none in the tail
   initial begin
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[adc_frame_channel_deframer] ERROR");
      $finish;
   end

   // Stimulus and verdict
   initial begin
      req_bus.valid       <= 1'b0;
      req_bus.device      <= 1'b0;
      req_bus.frame_start <= 1'b0;
      req_bus.byte_value  <= 8'h00;
      csr_write_enable    <= 1'b0;
      csr_write_data      <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Frame opened without a start flag right after reset, 24-bit mode
      drive_byte(1'b0, 1'b0, 8'hA5);
      drive_byte(1'b0, 1'b0, 8'h5A);
      drive_byte(1'b0, 1'b0, 8'h00);
      // most negative code, device changes on the closing byte
      drive_byte(1'b0, 1'b0, 8'h80);
      drive_byte(1'b0, 1'b0, 8'h00);
      drive_byte(1'b1, 1'b0, 8'h00);
      // most positive code
      drive_byte(1'b1, 1'b0, 8'h7F);
      drive_byte(1'b1, 1'b0, 8'hFF);
      drive_byte(1'b1, 1'b0, 8'hFF);
      // switch to 16-bit in the middle of the frame
      write_word_mode(MODE_16);
      drive_byte(1'b0, 1'b0, 8'hFF);
      drive_byte(1'b1, 1'b0, 8'h80);
      drive_byte(1'b0, 1'b0, 8'h00);
      drive_byte(1'b0, 1'b0, 8'hFF);
      // 32-bit frame, fourth byte of each word dropped
      write_word_mode(MODE_32);
      drive_byte(1'b1, 1'b1, 8'hFF);
      drive_byte(1'b1, 1'b0, 8'hFF);
      drive_byte(1'b1, 1'b0, 8'h00);
      drive_byte(1'b1, 1'b0, 8'h00);
      drive_byte(1'b0, 1'b0, 8'hFF);
      drive_byte(1'b0, 1'b0, 8'hFF);
      drive_byte(1'b0, 1'b0, 8'hFE);
      drive_byte(1'b0, 1'b0, 8'h55);
      // mode code 3 behaves as 24-bit
      write_word_mode(MODE_ALIAS_24);
      drive_byte(1'b0, 1'b1, 8'h01);
      drive_byte(1'b0, 1'b0, 8'h02);
      drive_byte(1'b0, 1'b0, 8'h03);
      drive_byte(1'b0, 1'b0, 8'h80);
      drive_byte(1'b0, 1'b0, 8'h00);
      drive_byte(1'b0, 1'b0, 8'h01);

      // Random frames across all word modes
      write_word_mode(MODE_16);
      run_traffic(310);
      write_word_mode(MODE_32);
      rsp_hold_request = 1'b1;
      run_traffic(310);
      write_word_mode(MODE_ALIAS_24);
      run_traffic(310);
      write_word_mode(MODE_24);
      run_traffic(310);
      write_word_mode(MODE_32);
      run_traffic(310);
      write_word_mode(MODE_16);
      run_traffic(250);
      quiet_tail    = 1'b1;
      sender_steady = 1'b1;
      run_traffic(60);

      // Drain and let the pipeline go quiet
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_samples != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("[adc_frame_channel_deframer] OK");
      end else begin
         $display("[adc_frame_channel_deframer] ERROR");
      end
      $finish;
   end

endmodule
